// File: design/skct_pkg.sv
// ----------------------------------------------------------------------------
// skct_pkg
// Types and constants shared by the sorted counted key table and its cells.
// ----------------------------------------------------------------------------
package skct_pkg;

  localparam int CAPACITY_DEF   = 32;
  localparam int KEY_BITS_DEF   = 64;
  localparam int COUNT_BITS_DEF = 16;

  localparam int KEY_FIELD_W  = 64;
  localparam int STAT_FIELD_W = 3;
  localparam int CNT_FIELD_W  = 16;
  localparam int ENT_FIELD_W  = 6;

  typedef enum logic {
    KIND_INSERT = 1'b0,
    KIND_REMOVE = 1'b1
  } kind_t;

  typedef enum logic [STAT_FIELD_W-1:0] {
    ST_RAISED    = 3'd0,
    ST_NEW       = 3'd1,
    ST_FULL      = 3'd2,
    ST_LOWERED   = 3'd3,
    ST_REMOVED   = 3'd4,
    ST_NOT_FOUND = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    OP_HOLD   = 3'd0,
    OP_INC    = 3'd1,
    OP_DEC    = 3'd2,
    OP_INSERT = 3'd3,
    OP_CLOSE  = 3'd4
  } cell_op_t;

  typedef struct packed {
    logic eq;
    logic gap;
  } cell_flags_t;

  typedef struct packed {
    logic                   kind;
    logic [KEY_FIELD_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [STAT_FIELD_W-1:0] status;
    logic [CNT_FIELD_W-1:0]  key_count;
    logic [ENT_FIELD_W-1:0]  entries;
  } out_item_t;

endpackage

// File: design/skct_cell.sv
// ----------------------------------------------------------------------------
// skct_cell
// One slot of the table: key and count, compare against the broadcast key,
// and load from itself, the broadcast key or either neighbour.
// ----------------------------------------------------------------------------
module skct_cell
  import skct_pkg::*;
#(
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [KEY_BITS-1:0]   op_key,
  input  logic                  valid,
  input  logic                  left_gap,
  input  logic [KEY_BITS-1:0]   left_key,
  input  logic [COUNT_BITS-1:0] left_count,
  input  logic [KEY_BITS-1:0]   right_key,
  input  logic [COUNT_BITS-1:0] right_count,
  output logic [KEY_BITS-1:0]   key_q,
  output logic [COUNT_BITS-1:0] count_q,
  output cell_flags_t           flags
);

  logic [KEY_BITS-1:0]   key_r;
  logic [KEY_BITS-1:0]   key_nxt;
  logic [COUNT_BITS-1:0] count_r;
  logic [COUNT_BITS-1:0] count_nxt;

  // gap: slot is empty or holds a smaller key, so it sits after the broadcast key
  always_comb begin
    flags.eq  = valid && (key_r == op_key);
    flags.gap = !valid || (key_r < op_key);
  end

  always_comb begin
    key_nxt   = key_r;
    count_nxt = count_r;
    case (op)
      OP_HOLD: begin
      end
      OP_INC: begin
        if (flags.eq && (count_r != {COUNT_BITS{1'b1}})) begin
          count_nxt = count_r + COUNT_BITS'(1);
        end
      end
      OP_DEC: begin
        if (flags.eq) begin
          count_nxt = count_r - COUNT_BITS'(1);
        end
      end
      OP_INSERT: begin
        if (flags.gap) begin
          if (left_gap) begin
            key_nxt   = left_key;
            count_nxt = left_count;
          end else begin
            key_nxt   = op_key;
            count_nxt = COUNT_BITS'(1);
          end
        end
      end
      OP_CLOSE: begin
        if (flags.gap || flags.eq) begin
          key_nxt   = right_key;
          count_nxt = right_count;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    count_r <= count_nxt;
  end

  assign key_q   = key_r;
  assign count_q = count_r;

endmodule

// File: design/sorted_counted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_counted_key_table
// A start transfer sets busy; the result is then registered with its strobe.
// One item at a time, as busy blocks a new start; compare in all cells, then
// at most one shift or count update along the cell chain.
// Reset clears occupancy, busy and strobe; slot contents are left as they are.
// Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module sorted_counted_key_table
  import skct_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int KEY_BITS   = KEY_BITS_DEF,
  parameter int COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  output logic      out_strobe,
  output out_item_t out_data
);

  localparam int OCC_W = $clog2(CAPACITY + 1);

  logic                  busy_r;
  logic                  kind_r;
  logic [KEY_BITS-1:0]   op_key_r;
  logic [OCC_W-1:0]      occ_r;
  logic [OCC_W-1:0]      occ_nxt;
  logic                  out_strobe_r;
  out_item_t             out_r;
  out_item_t             out_nxt;
  cell_op_t              op;

  logic [KEY_BITS-1:0]   cell_key   [CAPACITY];
  logic [COUNT_BITS-1:0] cell_count [CAPACITY];
  cell_flags_t           cell_flags [CAPACITY];
  logic [CAPACITY-1:0]   cell_valid;

  logic                  hit;
  logic [COUNT_BITS-1:0] hit_count;
  logic [COUNT_BITS-1:0] new_count;
  logic                  full;
  logic                  accept;

  assign accept = start && !busy_r;
  assign busy   = busy_r;
  assign full   = (occ_r == OCC_W'(CAPACITY));

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic                  lgap;
    logic [KEY_BITS-1:0]   lkey;
    logic [COUNT_BITS-1:0] lcnt;
    logic [KEY_BITS-1:0]   rkey;
    logic [COUNT_BITS-1:0] rcnt;

    assign cell_valid[i] = (OCC_W'(i) < occ_r);

    if (i == 0) begin : g_first
      assign lgap = 1'b0;
      assign lkey = '0;
      assign lcnt = '0;
    end else begin : g_mid
      assign lgap = cell_flags[i-1].gap;
      assign lkey = cell_key[i-1];
      assign lcnt = cell_count[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rkey = '0;
      assign rcnt = '0;
    end else begin : g_inner
      assign rkey = cell_key[i+1];
      assign rcnt = cell_count[i+1];
    end

    skct_cell #(
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS)
    ) u_cell (
      .clk         (clk),
      .op          (op),
      .op_key      (op_key_r),
      .valid       (cell_valid[i]),
      .left_gap    (lgap),
      .left_key    (lkey),
      .left_count  (lcnt),
      .right_key   (rkey),
      .right_count (rcnt),
      .key_q       (cell_key[i]),
      .count_q     (cell_count[i]),
      .flags       (cell_flags[i])
    );
  end

  always_comb begin
    hit       = 1'b0;
    hit_count = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit       = hit | cell_flags[i].eq;
      hit_count = hit_count | (cell_count[i] & {COUNT_BITS{cell_flags[i].eq}});
    end
  end

  always_comb begin
    op        = OP_HOLD;
    occ_nxt   = occ_r;
    new_count = '0;
    out_nxt   = out_r;
    if (busy_r) begin
      if (kind_r == KIND_INSERT) begin
        if (hit) begin
          op        = OP_INC;
          new_count = (hit_count == {COUNT_BITS{1'b1}}) ? hit_count
                                                        : hit_count + COUNT_BITS'(1);
          out_nxt.status = ST_RAISED;
        end else if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          op        = OP_INSERT;
          new_count = COUNT_BITS'(1);
          occ_nxt   = occ_r + OCC_W'(1);
          out_nxt.status = ST_NEW;
        end
      end else begin
        if (!hit) begin
          out_nxt.status = ST_NOT_FOUND;
        end else if (hit_count <= COUNT_BITS'(1)) begin
          op      = OP_CLOSE;
          occ_nxt = occ_r - OCC_W'(1);
          out_nxt.status = ST_REMOVED;
        end else begin
          op        = OP_DEC;
          new_count = hit_count - COUNT_BITS'(1);
          out_nxt.status = ST_LOWERED;
        end
      end
      out_nxt.key_count = CNT_FIELD_W'(new_count);
      out_nxt.entries   = ENT_FIELD_W'(occ_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      occ_r        <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      busy_r       <= accept;
      occ_r        <= occ_nxt;
      out_strobe_r <= busy_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r   <= in_data.kind;
      op_key_r <= KEY_BITS'(in_data.key);
    end
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sorted counted key table. A short directed
// script covers the field extremes and unsigned ordering. A fill phase drives
// the table full, and a run on one key raises its count and takes it back
// down. Random bursts, mostly from a small key pool, follow. Typed script rows
// are checked against their row, all else against a behavioural table copy.
// ----------------------------------------------------------------------------
module tb;
  import skct_pkg::*;

  localparam int TABLE_SLOTS = CAPACITY_DEF;
  localparam logic [CNT_FIELD_W-1:0] COUNT_TOP = '1;
  localparam int RANDOM_ITEMS = 1600;
  localparam int POOL_SIZE = 48;
  localparam int CYCLE_LIMIT = 1_500_000;
  localparam int REPEAT_RUN = 6;

  typedef struct packed {
    kind_t                   kind;
    logic [KEY_FIELD_W-1:0]  key;
    bit                      typed;
    status_t                 st;
    logic [CNT_FIELD_W-1:0]  cnt;
    logic [ENT_FIELD_W-1:0]  ent;
  } script_row_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  in_item_t  in_data = '0;
  logic      busy;
  logic      out_strobe;
  out_item_t out_data;

  logic [KEY_FIELD_W-1:0] held_keys [TABLE_SLOTS];
  logic [CNT_FIELD_W-1:0] held_counts [TABLE_SLOTS];
  int        held_used = 0;
  out_item_t pending_results [$];
  int        error_count = 0;
  int        cycle_count = 0;

  always #1 clk = ~clk;

  sorted_counted_key_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_strobe(out_strobe),
    .out_data  (out_data)
  );

  function automatic out_item_t table_update(input kind_t k, input logic [KEY_FIELD_W-1:0] key);
    out_item_t r;
    int slot;
    int pos;
    int i;
    r = '0;
    slot = held_used;
    for (i = 0; i < held_used; i++)
      if (slot == held_used && held_keys[i] == key) slot = i;
    if (k == KIND_INSERT) begin
      if (slot < held_used) begin
        if (held_counts[slot] != COUNT_TOP) held_counts[slot]++;
        r.status = ST_RAISED;
        r.key_count = held_counts[slot];
      end else if (held_used >= TABLE_SLOTS) begin
        r.status = ST_FULL;
      end else begin
        pos = held_used;
        for (i = 0; i < held_used; i++)
          if (pos == held_used && held_keys[i] < key) pos = i;
        for (i = held_used; i > pos; i--) begin
          held_keys[i] = held_keys[i-1];
          held_counts[i] = held_counts[i-1];
        end
        held_keys[pos] = key;
        held_counts[pos] = CNT_FIELD_W'(1);
        held_used++;
        r.status = ST_NEW;
        r.key_count = CNT_FIELD_W'(1);
      end
    end else begin
      if (slot < held_used) begin
        held_counts[slot]--;
        if (held_counts[slot] == 0) begin
          for (i = slot + 1; i < held_used; i++) begin
            held_keys[i-1] = held_keys[i];
            held_counts[i-1] = held_counts[i];
          end
          held_used--;
          r.status = ST_REMOVED;
        end else begin
          r.status = ST_LOWERED;
          r.key_count = held_counts[slot];
        end
      end else begin
        r.status = ST_NOT_FOUND;
      end
    end
    r.entries = held_used[ENT_FIELD_W-1:0];
    return r;
  endfunction

  task automatic send_item(input kind_t k, input logic [KEY_FIELD_W-1:0] key,
                           input bit typed, input out_item_t typed_result);
    out_item_t model_result;
    start <= 1'b1;
    in_data <= in_item_t'{kind: k, key: key};
    do @(posedge clk); while (busy !== 1'b0);
    model_result = table_update(k, key);
    pending_results.push_back(typed ? typed_result : model_result);
  endtask

  task automatic pause(input int cycles, input bit drain);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
    while (drain && pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic check_field(input string fname, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
    end
  endtask

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        error_count++;
        $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d", $time,
                 out_data.status, out_data.key_count, out_data.entries);
      end else begin
        want = pending_results.pop_front();
        check_field("status", 32'(want.status), 32'(out_data.status));
        check_field("key_count", 32'(want.key_count), 32'(out_data.key_count));
        check_field("entries", 32'(want.entries), 32'(out_data.entries));
      end
    end
  end

  initial begin
    script_row_t            script [24];
    logic [KEY_FIELD_W-1:0] key_pool [POOL_SIZE];
    logic [KEY_FIELD_W-1:0] fill_keys [TABLE_SLOTS];
    logic [KEY_FIELD_W-1:0] sat_key;
    logic [KEY_FIELD_W-1:0] pick;
    kind_t                  k;
    int                     sent;
    int                     burst;
    int                     ins_pct;
    int                     j;

    // "alpha", "alphabet", "alp" packed with the first character on top
    script[0]  = '{KIND_REMOVE, 64'h0,                   1'b1, ST_NOT_FOUND, 16'd0, 6'd0};
    script[1]  = '{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_NEW,       16'd1, 6'd1};
    script[2]  = '{KIND_INSERT, 64'h0,                   1'b1, ST_NEW,       16'd1, 6'd2};
    script[3]  = '{KIND_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_RAISED,    16'd2, 6'd2};
    script[4]  = '{KIND_INSERT, 64'h8000_0000_0000_0000, 1'b1, ST_NEW,       16'd1, 6'd3};
    script[5]  = '{KIND_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, ST_NEW,       16'd1, 6'd4};
    script[6]  = '{KIND_INSERT, 64'h616C_7068_6100_0000, 1'b1, ST_NEW,       16'd1, 6'd5};
    script[7]  = '{KIND_INSERT, 64'h616C_7068_6162_6574, 1'b1, ST_NEW,       16'd1, 6'd6};
    script[8]  = '{KIND_INSERT, 64'h616C_7000_0000_0000, 1'b1, ST_NEW,       16'd1, 6'd7};
    script[9]  = '{KIND_REMOVE, 64'h616C_7068_6100_0001, 1'b1, ST_NOT_FOUND, 16'd0, 6'd7};
    script[10] = '{KIND_REMOVE, 64'h0,                   1'b1, ST_REMOVED,   16'd0, 6'd6};
    script[11] = '{KIND_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_LOWERED,   16'd1, 6'd6};
    script[12] = '{KIND_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_REMOVED,   16'd0, 6'd5};
    script[13] = '{KIND_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_NOT_FOUND, 16'd0, 6'd5};
    script[14] = '{KIND_INSERT, 64'h5555_5555_5555_5555, 1'b1, ST_NEW,       16'd1, 6'd6};
    script[15] = '{KIND_INSERT, 64'h5555_5555_5555_5555, 1'b1, ST_RAISED,    16'd2, 6'd6};
    script[16] = '{KIND_REMOVE, 64'h8000_0000_0000_0000, 1'b0, ST_RAISED,    16'd0, 6'd0};
    script[17] = '{KIND_REMOVE, 64'h7FFF_FFFF_FFFF_FFFF, 1'b0, ST_RAISED,    16'd0, 6'd0};
    script[18] = '{KIND_REMOVE, 64'h616C_7068_6100_0000, 1'b0, ST_RAISED,    16'd0, 6'd0};
    script[19] = '{KIND_REMOVE, 64'h616C_7068_6162_6574, 1'b0, ST_RAISED,    16'd0, 6'd0};
    script[20] = '{KIND_REMOVE, 64'h616C_7000_0000_0000, 1'b0, ST_RAISED,    16'd0, 6'd0};
    script[21] = '{KIND_REMOVE, 64'h5555_5555_5555_5555, 1'b0, ST_RAISED,    16'd0, 6'd0};
    script[22] = '{KIND_REMOVE, 64'h5555_5555_5555_5555, 1'b0, ST_RAISED,    16'd0, 6'd0};
    script[23] = '{KIND_REMOVE, 64'h5555_5555_5555_5555, 1'b0, ST_RAISED,    16'd0, 6'd0};

    key_pool[0] = '0;
    key_pool[1] = '1;
    key_pool[2] = 64'h8000_0000_0000_0000;
    key_pool[3] = 64'h7FFF_FFFF_FFFF_FFFF;
    key_pool[4] = 64'h616C_7068_6100_0000;
    key_pool[5] = 64'h616C_7068_6162_6574;
    for (j = 6; j < POOL_SIZE; j++)
      key_pool[j] = (j % 4 == 0) ? key_pool[j-1] + 1 : {$urandom, $urandom};

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      send_item(script[i].kind, script[i].key, script[i].typed,
                out_item_t'{script[i].st, script[i].cnt, script[i].ent});
      if ($urandom_range(3) == 0) pause($urandom_range(1, 4), 1'b0);
    end
    pause(1, 1'b1);

    // ascending keys, so every insert shifts the whole table
    for (j = 0; j < TABLE_SLOTS; j++) begin
      fill_keys[j] = {6'(j + 1), 26'($urandom), $urandom};
      send_item(KIND_INSERT, fill_keys[j], 1'b0, '0);
    end
    send_item(KIND_INSERT, {6'd0, 26'($urandom), $urandom}, 1'b0, '0);
    send_item(KIND_INSERT, '1, 1'b0, '0);
    send_item(KIND_INSERT, fill_keys[5], 1'b0, '0);
    pause(2, 1'b1);
    for (j = 0; j < TABLE_SLOTS; j++)
      send_item(KIND_REMOVE, fill_keys[(j < TABLE_SLOTS / 2) ? 2 * j + 1
                                      : 2 * (j - TABLE_SLOTS / 2)], 1'b0, '0);
    send_item(KIND_REMOVE, fill_keys[5], 1'b0, '0);
    pause(1, 1'b1);

    // repeated copies of one key, raised and taken back down
    sat_key = {$urandom, $urandom};
    repeat (REPEAT_RUN) send_item(KIND_INSERT, sat_key, 1'b0, '0);
    repeat (REPEAT_RUN) send_item(KIND_REMOVE, sat_key, 1'b0, '0);
    pause(1, 1'b1);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 16);
      ins_pct = ((sent / 160) % 2 == 0) ? 75 : 30;
      repeat (burst) begin
        pick = ($urandom_range(99) < 85) ? key_pool[$urandom_range(POOL_SIZE - 1)]
                                         : {$urandom, $urandom};
        k = ($urandom_range(99) < ins_pct) ? KIND_INSERT : KIND_REMOVE;
        send_item(k, pick, 1'b0, '0);
        sent++;
      end
      case ($urandom_range(9))
        0: begin
          pause(1, 1'b1);
        end
        1, 2, 3: begin
        end
        default: begin
          pause($urandom_range(1, 6), 1'b0);
        end
      endcase
    end

    pause(1, 1'b1);
    repeat (4) @(posedge clk);
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: sim.f
design/skct_pkg.sv
design/skct_cell.sv
design/sorted_counted_key_table.sv
bench/tb.sv
